>>> hdl/siud_pkg.sv
`default_nettype none
package siud_pkg;

    typedef enum logic [2:0] {
        CMD_CLEAR     = 3'd0,
        CMD_APPEND_A  = 3'd1,
        CMD_APPEND_B  = 3'd2,
        CMD_INTERSECT = 3'd3,
        CMD_UNION     = 3'd4
    } t_cmd;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [31:0] value;
    } t_in_item;

    typedef struct packed {
        logic [31:0] result_value;
        logic        is_empty;
        logic        last;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_SCAN  = 2'd1,
        ST_DRAIN = 2'd2,
        ST_EMPTY = 2'd3
    } t_state;

    // Control broadcast from the sequencer to every cell of the chain.
    typedef struct packed {
        logic clear;
        logic shift;
    } t_cell_ctrl;

    // IEEE single equality: both zeros are equal, a NaN equals nothing.
    function automatic logic fp_eq(input logic [31:0] x, input logic [31:0] y);
        logic x_nan;
        logic y_nan;
        x_nan = (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
        y_nan = (y[30:23] == 8'hFF) && (y[22:0] != 23'd0);
        if (x_nan || y_nan) begin
            return 1'b0;
        end
        if ((x[30:0] == 31'd0) && (y[30:0] == 31'd0)) begin
            return 1'b1;
        end
        return x == y;
    endfunction

endpackage
`default_nettype wire

>>> hdl/siud_cell.sv
`default_nettype none
// One cell of the emitted chain: holds one unique value and passes it on.
module siud_cell (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire siud_pkg::t_cell_ctrl  i_ctrl,
    input  wire logic                  i_prev_valid,
    input  wire logic [31:0]           i_prev_value,
    input  wire logic [31:0]           i_probe,
    output logic                       o_valid,
    output logic [31:0]                o_value,
    output logic                       o_hit
);
    logic        r_valid;
    logic [31:0] r_value;

    // Shift in from the previous cell when the chain advances.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.clear) begin
            r_valid <= 1'b0;
        end else if (i_ctrl.shift) begin
            r_valid <= i_prev_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift) begin
            r_value <= i_prev_value;
        end
    end

    // Local compare of the held value against the probe.
    assign o_hit   = r_valid && siud_pkg::fp_eq(r_value, i_probe);
    assign o_valid = r_valid;
    assign o_value = r_value;
endmodule
`default_nettype wire

>>> hdl/set_intersection_union_dedup_core.sv
`default_nettype none
// Loads, clear and unknown commands hold busy low: the next item can follow in the next cycle.
// Intersection scans one A x B pair a cycle.
// Union scans A, then B, one element a cycle.
// The chain then drains (an empty answer is a single marker with is_empty set); results
// leave one per cycle from a register, the last one in the first cycle after busy falls.
// Synchronous active-low reset empties both sets and the chain; the receiver cannot stall.
module set_intersection_union_dedup_core #(
    parameter int SET_DEPTH = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire siud_pkg::t_in_item   i_item,
    output logic                      o_strobe,
    output siud_pkg::t_out_item       o_item
);
    localparam int EmitDepth = 2 * SET_DEPTH;
    localparam int Iw = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
    localparam int Cw = $clog2(SET_DEPTH + 1);
    localparam int Ew = $clog2(EmitDepth + 1);

    logic [31:0]  r_mem_a [SET_DEPTH];
    logic [31:0]  r_mem_b [SET_DEPTH];
    logic [31:0]  r_rd_a, r_rd_b;
    logic [Cw-1:0] r_cnt_a, r_cnt_b, n_cnt_a, n_cnt_b;
    logic [Ew-1:0] r_ecnt, n_ecnt;
    logic [Cw-1:0] r_i, r_j, n_i, n_j;
    logic          r_uni, n_uni, r_phb, n_phb;
    siud_pkg::t_state r_state, n_state;
    logic          r_strobe, n_strobe;
    siud_pkg::t_out_item r_out, n_out;

    logic [31:0] w_a, w_b, w_cand;
    logic        w_cand_v, w_any_hit;
    siud_pkg::t_cell_ctrl w_ctrl;
    logic        w_acc;

    logic        w_cv [EmitDepth+1];
    logic [31:0] w_cd [EmitDepth+1];
    logic [EmitDepth-1:0] w_hit;

    assign w_acc = start && !busy;
    assign busy  = (r_state != siud_pkg::ST_IDLE);

    // Set stores: written on appends.
    always_ff @(posedge i_clk) begin
        if (w_acc && i_item.cmd == siud_pkg::CMD_APPEND_A && r_cnt_a < Cw'(SET_DEPTH)) begin
            r_mem_a[r_cnt_a[Iw-1:0]] <= i_item.value;
        end
        if (w_acc && i_item.cmd == siud_pkg::CMD_APPEND_B && r_cnt_b < Cw'(SET_DEPTH)) begin
            r_mem_b[r_cnt_b[Iw-1:0]] <= i_item.value;
        end
    end

    // Registered reads at the next scan indexes, so the data lines up with r_i and r_j.
    always_ff @(posedge i_clk) begin
        r_rd_a <= r_mem_a[n_i[Iw-1:0]];
        r_rd_b <= r_mem_b[n_j[Iw-1:0]];
    end

    assign w_a = r_rd_a;
    assign w_b = r_rd_b;

    // Candidate of this scan cycle.
    always_comb begin
        w_cand   = w_b;
        w_cand_v = 1'b0;
        if (r_state == siud_pkg::ST_SCAN) begin
            if (r_uni) begin
                w_cand   = r_phb ? w_b : w_a;
                w_cand_v = r_phb ? (r_j < r_cnt_b) : (r_i < r_cnt_a);
            end else begin
                w_cand_v = (r_i < r_cnt_a) && (r_j < r_cnt_b) && siud_pkg::fp_eq(w_b, w_a);
            end
        end
    end

    assign w_any_hit = |w_hit;

    // Chain input: a new unique value during scan, an empty slot during drain.
    always_comb begin
        w_ctrl.clear = w_acc && (i_item.cmd == siud_pkg::CMD_INTERSECT ||
                                 i_item.cmd == siud_pkg::CMD_UNION);
        w_ctrl.shift = (r_state == siud_pkg::ST_DRAIN) ||
                       (w_cand_v && !w_any_hit && r_ecnt < Ew'(EmitDepth));
        w_cv[0] = (r_state == siud_pkg::ST_SCAN);
        w_cd[0] = w_cand;
    end

    genvar g;
    generate
        for (g = 0; g < EmitDepth; g++) begin : g_cell
            siud_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctrl       (w_ctrl),
                .i_prev_valid (w_cv[g]),
                .i_prev_value (w_cd[g]),
                .i_probe      (w_cand),
                .o_valid      (w_cv[g+1]),
                .o_value      (w_cd[g+1]),
                .o_hit        (w_hit[g])
            );
        end
    endgenerate

    // Next state.
    always_comb begin
        n_state = r_state;
        n_cnt_a = r_cnt_a;
        n_cnt_b = r_cnt_b;
        n_i = r_i;
        n_j = r_j;
        n_uni = r_uni;
        n_phb = r_phb;
        n_ecnt = r_ecnt;
        case (r_state)
            siud_pkg::ST_IDLE: begin
                if (w_acc) begin
                    case (i_item.cmd)
                        siud_pkg::CMD_CLEAR: begin
                            n_cnt_a = '0;
                            n_cnt_b = '0;
                        end
                        siud_pkg::CMD_APPEND_A: begin
                            if (r_cnt_a < Cw'(SET_DEPTH)) n_cnt_a = r_cnt_a + 1'b1;
                        end
                        siud_pkg::CMD_APPEND_B: begin
                            if (r_cnt_b < Cw'(SET_DEPTH)) n_cnt_b = r_cnt_b + 1'b1;
                        end
                        siud_pkg::CMD_INTERSECT, siud_pkg::CMD_UNION: begin
                            n_state = siud_pkg::ST_SCAN;
                            n_i = '0;
                            n_j = '0;
                            n_phb = 1'b0;
                            n_ecnt = '0;
                            n_uni = (i_item.cmd == siud_pkg::CMD_UNION);
                        end
                        default: begin
                        end
                    endcase
                end
            end
            siud_pkg::ST_SCAN: begin
                if (w_ctrl.shift) n_ecnt = r_ecnt + 1'b1;
                if (r_uni) begin
                    if (!r_phb) begin
                        if (r_i < r_cnt_a) n_i = r_i + 1'b1;
                        else n_phb = 1'b1;
                    end else if (r_j < r_cnt_b) begin
                        n_j = r_j + 1'b1;
                    end else begin
                        n_state = (r_ecnt == '0) ? siud_pkg::ST_EMPTY : siud_pkg::ST_DRAIN;
                    end
                end else begin
                    if (r_i >= r_cnt_a || r_cnt_b == '0) begin
                        n_state = (r_ecnt == '0) ? siud_pkg::ST_EMPTY : siud_pkg::ST_DRAIN;
                    end else if (r_j + 1'b1 >= r_cnt_b) begin
                        n_j = '0;
                        n_i = r_i + 1'b1;
                    end else begin
                        n_j = r_j + 1'b1;
                    end
                end
            end
            siud_pkg::ST_DRAIN: begin
                if (w_cv[EmitDepth]) n_ecnt = r_ecnt - 1'b1;
                if (w_cv[EmitDepth] && r_ecnt == Ew'(1)) n_state = siud_pkg::ST_IDLE;
            end
            siud_pkg::ST_EMPTY: n_state = siud_pkg::ST_IDLE;
            default: n_state = siud_pkg::ST_IDLE;
        endcase
    end

    // Outputs: the oldest value leaves the far end of the chain first.
    always_comb begin
        n_strobe = 1'b0;
        n_out = '0;
        case (r_state)
            siud_pkg::ST_DRAIN: begin
                n_strobe = w_cv[EmitDepth];
                n_out.result_value = w_cd[EmitDepth];
                n_out.last = (r_ecnt == Ew'(1));
            end
            siud_pkg::ST_EMPTY: begin
                n_strobe = 1'b1;
                n_out.is_empty = 1'b1;
                n_out.last = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= siud_pkg::ST_IDLE;
            r_cnt_a <= '0;
            r_cnt_b <= '0;
            r_ecnt <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt_a <= n_cnt_a;
            r_cnt_b <= n_cnt_b;
            r_ecnt <= n_ecnt;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i <= n_i;
        r_j <= n_j;
        r_uni <= n_uni;
        r_phb <= n_phb;
        r_out <= n_out;
    end

    assign o_strobe = r_strobe;
    assign o_item = r_out;
endmodule
`default_nettype wire

>>> hdl/siud_checker.sv
`default_nettype none
// Port-level checks of the result stream.
module siud_checker (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                busy,
    input wire logic                o_strobe,
    input wire siud_pkg::t_out_item o_item
);
    // An empty marker always closes the run.
    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_item.is_empty |-> o_item.last)
        else $error("empty result without last");

    // An empty marker carries a zero value.
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_item.is_empty |-> o_item.result_value == 32'd0)
        else $error("empty result with nonzero value");

    // Results other than the last appear only while a command is in work.
    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_item.last |-> busy)
        else $error("result outside a command");

    // After a last result nothing follows in the next cycle.
    a_last_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_item.last |=> !o_strobe)
        else $error("result after last");
endmodule

bind set_intersection_union_dedup_core siud_checker u_siud_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .busy     (busy),
    .o_strobe (o_strobe),
    .o_item   (o_item)
);
`default_nettype wire

>>> bench/tb_set_intersection_union_dedup_core.sv
`default_nettype none
module tb_set_intersection_union_dedup_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 16;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam logic [2:0] CMD_BAD_LO = 3'd5;
    localparam logic [2:0] CMD_BAD_HI = 3'd7;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    siud_pkg::t_in_item  i_item = '0;
    logic                o_strobe;
    siud_pkg::t_out_item o_item;

    set_intersection_union_dedup_core #(.SET_DEPTH(DEPTH)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_item(i_item), .o_strobe(o_strobe), .o_item(o_item)
    );

    always #4 i_clk = ~i_clk;

    // Model state of the two sets.
    logic [31:0] set_a [DEPTH];
    logic [31:0] set_b [DEPTH];
    int          len_a;
    int          len_b;
    siud_pkg::t_out_item answer_q[$];

    int error_count = 0;
    int idle_pct = 0;
    int quiet_cycles = 0;

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        error_count++;
    endtask

    // Float equality on bit patterns: zeros equal, NaN equals nothing.
    function automatic bit float_same(input logic [31:0] x, input logic [31:0] y);
        bit xn;
        bit yn;
        xn = (x[30:23] == 8'hFF) && (x[22:0] != 0);
        yn = (y[30:23] == 8'hFF) && (y[22:0] != 0);
        if (xn || yn) return 1'b0;
        if (x[30:0] == 0 && y[30:0] == 0) return 1'b1;
        return x == y;
    endfunction

    // Updates the set model and queues the answer for one accepted command.
    task automatic predict_answer(input siud_pkg::t_in_item it);
        logic [31:0] seen[$];
        logic [31:0] cand[$];
        bit dup;
        siud_pkg::t_out_item r;
        case (it.cmd)
            siud_pkg::CMD_CLEAR: begin
                len_a = 0;
                len_b = 0;
            end
            siud_pkg::CMD_APPEND_A: if (len_a < DEPTH) begin
                set_a[len_a] = it.value;
                len_a++;
            end
            siud_pkg::CMD_APPEND_B: if (len_b < DEPTH) begin
                set_b[len_b] = it.value;
                len_b++;
            end
            siud_pkg::CMD_INTERSECT, siud_pkg::CMD_UNION: begin
                if (it.cmd == siud_pkg::CMD_INTERSECT) begin
                    for (int i = 0; i < len_a; i++)
                        for (int j = 0; j < len_b; j++)
                            if (float_same(set_b[j], set_a[i])) cand.push_back(set_b[j]);
                end else begin
                    for (int i = 0; i < len_a; i++) cand.push_back(set_a[i]);
                    for (int j = 0; j < len_b; j++) cand.push_back(set_b[j]);
                end
                foreach (cand[k]) begin
                    dup = 1'b0;
                    foreach (seen[m]) if (float_same(seen[m], cand[k])) dup = 1'b1;
                    if (!dup) seen.push_back(cand[k]);
                end
                if (seen.size() == 0) begin
                    r.result_value = '0;
                    r.is_empty = 1'b1;
                    r.last = 1'b1;
                    answer_q.push_back(r);
                end else begin
                    foreach (seen[k]) begin
                        r.result_value = seen[k];
                        r.is_empty = 1'b0;
                        r.last = (k == seen.size() - 1);
                        answer_q.push_back(r);
                    end
                end
            end
            default: ;
        endcase
    endtask

    // Sends one command, with random idle cycles in front of it.
    // Start stays high after the accepting edge until the next idle cycle or new item.
    task automatic send_item(input logic [2:0] cmd, input logic [31:0] value);
        siud_pkg::t_in_item it;
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        it.cmd = cmd;
        it.value = value;
        start <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        predict_answer(it);
    endtask

    // Checks every result against the oldest expected one.
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (answer_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result %h", o_item));
            end else begin
                if (o_item.result_value !== answer_q[0].result_value)
                    report_mismatch($sformatf("value %h, wanted %h",
                        o_item.result_value, answer_q[0].result_value));
                if (o_item.is_empty !== answer_q[0].is_empty)
                    report_mismatch($sformatf("is_empty %b, wanted %b",
                        o_item.is_empty, answer_q[0].is_empty));
                if (o_item.last !== answer_q[0].last)
                    report_mismatch($sformatf("last %b, wanted %b",
                        o_item.last, answer_q[0].last));
                void'(answer_q.pop_front());
            end
        end
    end

    // Watchdog on cycles with no handshake at all.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("set_intersection_union_dedup_core regression: fail");
            $finish;
        end
    end

    // Drops start and waits until every expected result has come.
    task automatic wait_answers_done();
        start <= 1'b0;
        while (answer_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Random value, drawn often from a small pool so that matches happen.
    function automatic logic [31:0] pick_value();
        logic [31:0] pool [8] = '{32'h0000_0000, 32'h8000_0000, 32'h3F80_0000,
            32'hBF80_0000, 32'h7F80_0000, 32'h7FC0_0000, 32'hFFFF_FFFF, 32'h4000_0000};
        if ($urandom_range(2) != 0) return pool[$urandom_range(7)];
        return $urandom();
    endfunction

    task automatic test_directed();
        send_item(siud_pkg::CMD_INTERSECT, 32'h0);
        send_item(siud_pkg::CMD_UNION, 32'hFFFF_FFFF);
        send_item(siud_pkg::CMD_APPEND_A, 32'h0000_0000);
        send_item(siud_pkg::CMD_APPEND_A, 32'h7FC0_0001);
        send_item(siud_pkg::CMD_APPEND_A, 32'hFFFF_FFFF);
        send_item(siud_pkg::CMD_APPEND_A, 32'h3F80_0000);
        send_item(siud_pkg::CMD_APPEND_B, 32'h8000_0000);
        send_item(siud_pkg::CMD_APPEND_B, 32'h7FC0_0001);
        send_item(siud_pkg::CMD_APPEND_B, 32'h3F80_0000);
        send_item(siud_pkg::CMD_APPEND_B, 32'h3F80_0000);
        send_item(siud_pkg::CMD_INTERSECT, 32'h0);
        send_item(siud_pkg::CMD_UNION, 32'h0);
        send_item(CMD_BAD_LO, 32'h1234_5678);
        send_item(CMD_BAD_HI, 32'h0);
        send_item(siud_pkg::CMD_CLEAR, 32'h0);
        send_item(siud_pkg::CMD_UNION, 32'h0);
    endtask

    // Fill both sets beyond capacity; extra appends must be dropped.
    task automatic test_full_sets();
        for (int k = 0; k < DEPTH + 2; k++) send_item(siud_pkg::CMD_APPEND_A, pick_value());
        for (int k = 0; k < DEPTH + 2; k++) send_item(siud_pkg::CMD_APPEND_B, pick_value());
        send_item(siud_pkg::CMD_UNION, 32'h0);
        send_item(siud_pkg::CMD_INTERSECT, 32'h0);
        // Hold off until the whole answer has drained.
        wait_answers_done();
        send_item(siud_pkg::CMD_CLEAR, 32'h0);
    endtask

    // Random sequences: mostly loads followed by compute, some noise.
    task automatic test_random(input int n_items);
        int sent;
        int r;
        sent = 0;
        while (sent < n_items) begin
            r = $urandom_range(99);
            if (r < 4) send_item(siud_pkg::CMD_CLEAR, $urandom());
            else if (r < 38) send_item(siud_pkg::CMD_APPEND_A, pick_value());
            else if (r < 72) send_item(siud_pkg::CMD_APPEND_B, pick_value());
            else if (r < 84) send_item(siud_pkg::CMD_INTERSECT, $urandom());
            else if (r < 96) send_item(siud_pkg::CMD_UNION, $urandom());
            else send_item(3'($urandom_range(CMD_BAD_HI, CMD_BAD_LO)), $urandom());
            sent++;
        end
    endtask

    initial begin
        len_a = 0;
        len_b = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        idle_pct = 35;
        test_directed();
        test_full_sets();
        test_random(90);
        idle_pct = 59;
        test_random(90);
        idle_pct = 0;
        test_random(90);
        wait_answers_done();
        repeat (50) @(posedge i_clk);
        if (error_count == 0 && answer_q.size() == 0) begin
            $display("set_intersection_union_dedup_core regression: pass");
        end else begin
            $display("set_intersection_union_dedup_core regression: fail");
        end
        $finish;
    end
endmodule
`default_nettype wire
